@@ hw/rtl/qn_pkg.sv @@
package qn_pkg;

  localparam int NewtonSteps   = 2;
  localparam int SeedTableBits = 6;

  localparam int CompW = 16;
  localparam int YW    = 31;
  localparam int MantW = 32;
  localparam int SumW  = 33;
  localparam int KW    = 5;

  localparam logic [YW-1:0]    OneQ30   = 31'h4000_0000;
  localparam logic [MantW-1:0] ThreeQ30 = 32'hC000_0000;
  localparam logic [CompW-1:0] UnitMax  = 16'd16384;

  // per-item data that rides along the whole pipe
  typedef struct packed {
    logic [3:0][CompW-1:0] comp;
    logic                  last;
    logic                  zero;
    logic [KW-1:0]         k;
  } qn_side_t;

  // reciprocal root estimate together with its reduced operand
  typedef struct packed {
    logic [YW-1:0]    y;
    logic [MantW-1:0] mant;
    qn_side_t         side;
  } qn_est_t;

  // magnitude of a two's complement component, most negative gives 32768
  function automatic logic [CompW-1:0] mag16(input logic [CompW-1:0] v);
    logic [CompW-1:0] m;
    m = v[CompW-1] ? (~v + 16'd1) : v;
    return m;
  endfunction

  // seed for bin idx: largest y <= 1.0 with floor(y*y) * mid <= 1, all Q.30
  function automatic logic [YW-1:0] seed_value(input int idx, input int bits);
    logic [63:0] mid;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] probe;
    logic [63:0] sq;
    mid = ((64'(idx) << 1) | 64'd1) << (31 - bits);
    lo  = 64'd0;
    hi  = 64'd1 << 30;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        probe = lo + ((hi - lo + 64'd1) >> 1);
        sq    = (probe * probe) >> 30;
        if (sq * mid <= (64'd1 << 60)) begin
          lo = probe;
        end else begin
          hi = probe - 64'd1;
        end
      end
    end
    return lo[YW-1:0];
  endfunction

endpackage

@@ hw/rtl/qn_front.sv @@
module qn_front #(
  parameter int SEED_TABLE_BITS = qn_pkg::SeedTableBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [3:0][qn_pkg::CompW-1:0]          in_comp_i,
  input  logic                                   in_last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output qn_pkg::qn_est_t                        out_est_o
);

  localparam int NStg     = 4;
  localparam int TabDepth = 2 ** SEED_TABLE_BITS;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage a: squares
  logic [3:0][30:0]  sq_d, sq_q;
  qn_pkg::qn_side_t  sa_d, sa_q;

  always_comb begin
    logic [qn_pkg::CompW-1:0] m;
    logic [31:0]              p;
    for (int j = 0; j < 4; j++) begin
      m       = qn_pkg::mag16(in_comp_i[j]);
      p       = 32'(m) * 32'(m);
      sq_d[j] = p[30:0];
    end
    sa_d      = '0;
    sa_d.comp = in_comp_i;
    sa_d.last = in_last_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sq_q <= sq_d;
      sa_q <= sa_d;
    end
  end

  // stage b: sum of squares and exponent pair count
  logic [qn_pkg::SumW-1:0] sum_d, sum_q;
  qn_pkg::qn_side_t        sb_d, sb_q;

  always_comb begin
    sum_d = 33'(sq_q[0]) + 33'(sq_q[1]) + 33'(sq_q[2]) + 33'(sq_q[3]);
    sb_d  = sa_q;
    sb_d.zero = (sum_d == '0);
    sb_d.k    = '0;
    for (int p = 0; p < qn_pkg::SumW; p++) begin
      if (sum_d[p]) sb_d.k = qn_pkg::KW'(p >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sum_q <= sum_d;
      sb_q  <= sb_d;
    end
  end

  // stage c: range reduction to m in [1,4), Q2.30
  logic [qn_pkg::MantW-1:0] mant_d, mant_q;
  qn_pkg::qn_side_t         sc_q;

  always_comb begin
    logic [5:0]  k2;
    logic [62:0] shl;
    logic [32:0] shr;
    k2  = {sb_q.k, 1'b0};
    shl = 63'(sum_q) << (6'd30 - k2);
    shr = sum_q >> (k2 - 6'd30);
    if (k2 <= 6'd30) begin
      mant_d = shl[qn_pkg::MantW-1:0];
    end else begin
      mant_d = shr[qn_pkg::MantW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mant_q <= mant_d;
      sc_q   <= sb_q;
    end
  end

  // stage d: seed lookup
  logic [qn_pkg::YW-1:0]      seed_tab [TabDepth];
  logic [SEED_TABLE_BITS-1:0] idx;
  qn_pkg::qn_est_t            est_q;

  for (genvar g = 0; g < TabDepth; g++) begin : g_seed
    assign seed_tab[g] = qn_pkg::seed_value(g, SEED_TABLE_BITS);
  end

  assign idx = mant_q[qn_pkg::MantW-1 -: SEED_TABLE_BITS];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      est_q.y    <= seed_tab[idx];
      est_q.mant <= mant_q;
      est_q.side <= sc_q;
    end
  end

  assign out_est_o = est_q;

endmodule

@@ hw/rtl/qn_newton.sv @@
module qn_newton (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qn_pkg::qn_est_t in_est_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output qn_pkg::qn_est_t out_est_o
);

  localparam int NStg = 3;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage 1: t = y*y
  logic [61:0]           yy;
  logic [30:0]           t_q;
  qn_pkg::qn_est_t       e1_q;

  assign yy = 62'(in_est_i.y) * 62'(in_est_i.y);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t_q  <= yy[60:30];
      e1_q <= in_est_i;
    end
  end

  // stage 2: u = t*m, h = 1.5 - u/2 in Q.31 terms, clamped at zero
  logic [62:0]              tm;
  logic [31:0]              u;
  logic [qn_pkg::MantW-1:0] h_d, h_q;
  qn_pkg::qn_est_t          e2_q;

  assign tm  = 63'(t_q) * 63'(e1_q.mant);
  assign u   = tm[61:30];
  assign h_d = (u > qn_pkg::ThreeQ30) ? '0 : (qn_pkg::ThreeQ30 - u);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      h_q  <= h_d;
      e2_q <= e1_q;
    end
  end

  // stage 3: y*h, saturated at 1.0
  logic [62:0]     yh;
  logic [31:0]     r;
  qn_pkg::qn_est_t e3_q;

  assign yh = 63'(e2_q.y) * 63'(h_q);
  assign r  = yh[62:31];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      e3_q.mant <= e2_q.mant;
      e3_q.side <= e2_q.side;
      e3_q.y    <= (r > 32'(qn_pkg::OneQ30)) ? qn_pkg::OneQ30 : r[qn_pkg::YW-1:0];
    end
  end

  assign out_est_o = e3_q;

endmodule

@@ hw/rtl/qn_scale.sv @@
module qn_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  qn_pkg::qn_est_t               in_est_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0][qn_pkg::CompW-1:0] out_unit_o,
  output logic                          out_zero_o,
  output logic                          out_last_o
);

  localparam int NStg = 2;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    en[0]      = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  // stage 1: |c| * y
  logic [3:0][45:0]  prod_d, prod_q;
  qn_pkg::qn_side_t  s1_q;

  always_comb begin
    logic [46:0] p;
    for (int j = 0; j < 4; j++) begin
      p         = 47'(qn_pkg::mag16(in_est_i.side.comp[j])) * 47'(in_est_i.y);
      prod_d[j] = p[45:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
      s1_q   <= in_est_i.side;
    end
  end

  // stage 2: round half away from zero, saturate, restore sign
  logic [3:0][qn_pkg::CompW-1:0] unit_d, unit_q;
  logic                          zero_q;
  logic                          last_q;

  always_comb begin
    logic [5:0]               sh;
    logic [46:0]              rnd;
    logic [46:0]              q;
    logic [qn_pkg::CompW-1:0] qs;
    sh  = 6'(s1_q.k) + 6'd16;
    rnd = 47'd1 << (sh - 6'd1);
    for (int j = 0; j < 4; j++) begin
      q  = (47'(prod_q[j]) + rnd) >> sh;
      qs = (q > 47'(qn_pkg::UnitMax)) ? qn_pkg::UnitMax : q[qn_pkg::CompW-1:0];
      if (s1_q.zero) begin
        unit_d[j] = '0;
      end else if (s1_q.comp[j][qn_pkg::CompW-1]) begin
        unit_d[j] = ~qs + 16'd1;
      end else begin
        unit_d[j] = qs;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      unit_q <= unit_d;
      zero_q <= s1_q.zero;
      last_q <= s1_q.last;
    end
  end

  assign out_unit_o = unit_q;
  assign out_zero_o = zero_q;
  assign out_last_o = last_q;

endmodule

@@ hw/rtl/quaternion_normalizer.sv @@
// quaternion_normalizer: scales a stream of quaternions to unit length
// input channel s_axis: one transfer per quaternion, four signed q3.12
//   components in tdata (x lowest), tlast marks the final joint of a pose
// output channel m_axis: one transfer per input, four signed q1.14 unit
//   components in tdata (x lowest), tuser flags a zero-length quaternion
//   (components then all zero), tlast copies the input marker
// pipeline: 6 + 3 * NEWTON_STEPS register stages (12 at the default of two
//   steps): 4 front stages (squares, sum and exponent, range reduction,
//   seed rom), 3 per newton step (y*y, t*m, y*h), 2 output stages
//   (product, round and saturate)
// throughput: one quaternion per cycle while m_axis_tready stays high;
//   each multiplier has its own stage
// reset: all stage valid bits clear, the pipe comes up empty and ready
// receiver stall: every stage holds while the stage after it is full and
//   not advancing; bubbles still collapse, and s_axis_tready drops only
//   when the whole pipe is full, so nothing is lost or repeated
// seed rom: 2**SEED_TABLE_BITS constant entries, built at elaboration
module quaternion_normalizer #(
  parameter int NEWTON_STEPS    = qn_pkg::NewtonSteps,
  parameter int SEED_TABLE_BITS = qn_pkg::SeedTableBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // comp_x, comp_y, comp_z, comp_w
  input  logic        s_axis_tlast,  // last_joint
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // unit_x, unit_y, unit_z, unit_w
  output logic        m_axis_tuser,  // zero_length
  output logic        m_axis_tlast   // last_out
);

  // handshake and estimate between sections, index 0 is the front output
  logic                  sec_valid [NEWTON_STEPS+1];
  logic                  sec_ready [NEWTON_STEPS+1];
  qn_pkg::qn_est_t       sec_est   [NEWTON_STEPS+1];
  logic [3:0][15:0]      comp_in;
  logic [3:0][15:0]      unit_out;

  assign comp_in = s_axis_tdata;

  // squares, range reduction and seed
  qn_front #(
    .SEED_TABLE_BITS(SEED_TABLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_comp_i  (comp_in),
    .in_last_i  (s_axis_tlast),
    .out_valid_o(sec_valid[0]),
    .out_ready_i(sec_ready[0]),
    .out_est_o  (sec_est[0])
  );

  // one pipelined refinement section per newton step
  for (genvar n = 0; n < NEWTON_STEPS; n++) begin : g_newton
    qn_newton u_newton (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (sec_valid[n]),
      .in_ready_o (sec_ready[n]),
      .in_est_i   (sec_est[n]),
      .out_valid_o(sec_valid[n+1]),
      .out_ready_i(sec_ready[n+1]),
      .out_est_o  (sec_est[n+1])
    );
  end

  // scaling; its last stage is the output register
  qn_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sec_valid[NEWTON_STEPS]),
    .in_ready_o (sec_ready[NEWTON_STEPS]),
    .in_est_i   (sec_est[NEWTON_STEPS]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_unit_o (unit_out),
    .out_zero_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = unit_out;

endmodule
